@@ hw/rtl/scst_pkg.sv @@
package scst_pkg;

	localparam int WINDOW_LENGTH  = 480;
	localparam int RECOUNT_PERIOD = 8;

	localparam int WIN_AW   = $clog2(WINDOW_LENGTH);
	localparam int FILL_W   = $clog2(WINDOW_LENGTH + 1);
	localparam int PHASE_W  = $clog2(RECOUNT_PERIOD + 1);

	localparam int LEVEL_W  = 24;
	localparam int WEIGHT_W = 16;
	localparam int RATE_W   = 8;
	localparam int SCORE_W  = 7;
	localparam int BAND_W   = 2;
	localparam int CFG_AW   = 2;

	// 1e6 microsiemens-ohm scaled by 2^16 for the Q8.16 quotient.
	localparam int DIV_STEPS = 36;
	localparam logic [DIV_STEPS-1:0] DIVIDEND = 36'd65536000000;

	localparam logic [CFG_AW-1:0] REG_ENTER  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_EXIT   = 2'd1;
	localparam logic [CFG_AW-1:0] REG_WEIGHT = 2'd2;

	localparam logic [LEVEL_W-1:0]  ENTER_RESET  = 24'd655;
	localparam logic [LEVEL_W-1:0]  EXIT_RESET   = 24'd328;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd809;

endpackage

@@ hw/rtl/scst_ram.sv @@
module scst_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 480
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/skin_conductance_stress_tracker.sv @@
// Each accepted word passes through the serial divider, the difference, the serial multiplier,
// the tonic update and the window write; on every RECOUNT_PERIOD-th sample the window scan reads all entries.
// A new word is taken only after the last result is loaded into the output register; the
// 36-step serial divider, the 16-step serial multiplier and the window scan set this,
// and a result still held by a stalled receiver delays the next result further.
// Reset clears control state and the tonic level; unwritten window entries read as zero via a fill count.
module skin_conductance_stress_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [scst_pkg::LEVEL_W-1:0]       skin_ohms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [scst_pkg::LEVEL_W-1:0]       tonic_level,
	output logic [scst_pkg::LEVEL_W-1:0]       phasic_level,
	output logic [scst_pkg::RATE_W-1:0]        event_rate,
	output logic [scst_pkg::SCORE_W-1:0]       stress_pct,
	output logic [scst_pkg::BAND_W-1:0]        arousal_band,
	input  logic                               cfg_we,
	input  logic [scst_pkg::CFG_AW-1:0]        cfg_index,
	input  logic [scst_pkg::LEVEL_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_DIFF, ST_MUL, ST_TONIC, ST_WRITE, ST_SCAN, ST_DONE
	} state_t;

	localparam int LW = scst_pkg::LEVEL_W;
	localparam int WW = scst_pkg::WEIGHT_W;
	localparam int AW = scst_pkg::WIN_AW;
	localparam int PW = LW + 1 + WW;

	state_t state_q;

	logic [LW-1:0] enter_q, exit_q;
	logic [WW-1:0] weight_q;

	logic [LW-1:0]                  divisor_q, rem_q, quo_q;
	logic                           ovf_q;
	logic [scst_pkg::DIV_STEPS-1:0] dsh_q;
	logic [5:0]                     cnt_q;
	logic [LW-1:0]                  cond_q, tonic_q;
	logic signed [LW:0]             diff_q;
	logic signed [PW-1:0]           prod_q;
	logic [WW-1:0]                  wsh_q;

	logic [AW-1:0]                  wpos_q, scan_addr_q;
	logic [scst_pkg::FILL_W-1:0]    fill_q;
	logic [scst_pkg::PHASE_W-1:0]   phase_q;
	logic [LW-1:0]                  phasic_q;
	logic [scst_pkg::RATE_W-1:0]    held_q, count_q;
	logic                           inside_q, scan_issue_q;
	logic                           rd_act_s1, rd_ok_s1, rd_last_s1;

	logic                           out_valid_q;
	logic [LW-1:0]                  out_tonic_q, out_phasic_q;
	logic [scst_pkg::RATE_W-1:0]    out_rate_q;
	logic [scst_pkg::SCORE_W-1:0]   out_score_q;
	logic [scst_pkg::BAND_W-1:0]    out_band_q;

	// Serial restoring division, one quotient bit per cycle.
	logic [LW:0]   trial;
	logic          qbit;
	logic [LW-1:0] rem_next, quo_next;
	logic          ovf_next;

	always_comb begin
		trial    = {rem_q, dsh_q[scst_pkg::DIV_STEPS-1]} - {1'b0, divisor_q};
		qbit     = !trial[LW];
		rem_next = qbit ? trial[LW-1:0] : {rem_q[LW-2:0], dsh_q[scst_pkg::DIV_STEPS-1]};
		quo_next = {quo_q[LW-2:0], qbit};
		ovf_next = ovf_q | quo_q[LW-1];
	end

	logic signed [PW-1:0] addend, prod_rnd;
	logic [LW-1:0]        phasic_now;

	always_comb begin
		addend     = wsh_q[WW-1] ? PW'(diff_q) : '0;
		prod_rnd   = prod_q + PW'(32768);
		phasic_now = (cond_q > tonic_q) ? cond_q - tonic_q : '0;
	end

	logic [LW-1:0] rdata, sample;
	logic          inside_mid, enter_hit;

	scst_ram #(.WIDTH(LW), .DEPTH(scst_pkg::WINDOW_LENGTH)) u_window (
		.clk  (clk),
		.we   (state_q == ST_WRITE),
		.waddr(wpos_q),
		.wdata(phasic_now),
		.raddr(scan_addr_q),
		.rdata(rdata)
	);

	always_comb begin
		sample     = rd_ok_s1 ? rdata : '0;
		enter_hit  = !inside_q && (sample > enter_q);
		inside_mid = inside_q || enter_hit;
	end

	function automatic logic [scst_pkg::SCORE_W-1:0] SCORE_W_CAST(
		input logic [8:0] a, input logic [9:0] b);
		logic [9:0] s;
		s = {1'b0, a} + b;
		return s[scst_pkg::SCORE_W-1:0];
	endfunction

	logic [8:0]                   level_term;
	logic [9:0]                   rate_term;
	logic [scst_pkg::SCORE_W-1:0] score;
	logic [scst_pkg::BAND_W-1:0]  band;

	always_comb begin
		level_term = (tonic_q[LW-1:15] > 9'd40) ? 9'd40 : tonic_q[LW-1:15];
		rate_term  = {held_q, 2'b00};
		if (rate_term > 10'd60) begin
			rate_term = 10'd60;
		end
		score = SCORE_W_CAST(level_term, rate_term);
		if (score < 7'd25) begin
			band = 2'd0;
		end else if (score < 7'd50) begin
			band = 2'd1;
		end else if (score < 7'd75) begin
			band = 2'd2;
		end else begin
			band = 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q  <= scst_pkg::ENTER_RESET;
			exit_q   <= scst_pkg::EXIT_RESET;
			weight_q <= scst_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				scst_pkg::REG_ENTER:  enter_q  <= cfg_data;
				scst_pkg::REG_EXIT:   exit_q   <= cfg_data;
				scst_pkg::REG_WEIGHT: weight_q <= cfg_data[WW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tonic_q      <= '0;
			wpos_q       <= '0;
			fill_q       <= '0;
			phase_q      <= '0;
			held_q       <= '0;
			out_valid_q  <= 1'b0;
			rd_act_s1    <= 1'b0;
			scan_issue_q <= 1'b0;
		end else begin
			// In ST_DONE the output register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			rd_act_s1  <= scan_issue_q;
			rd_ok_s1   <= scst_pkg::FILL_W'(scan_addr_q) < fill_q;
			rd_last_s1 <= scan_addr_q == AW'(scst_pkg::WINDOW_LENGTH - 1);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						divisor_q <= skin_ohms;
						rem_q     <= '0;
						quo_q     <= '0;
						ovf_q     <= 1'b0;
						dsh_q     <= scst_pkg::DIVIDEND;
						cnt_q     <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					ovf_q <= ovf_next;
					dsh_q <= {dsh_q[scst_pkg::DIV_STEPS-2:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(scst_pkg::DIV_STEPS - 1)) begin
						cond_q  <= ovf_next ? '1 : quo_next;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					diff_q  <= $signed({1'b0, cond_q}) - $signed({1'b0, tonic_q});
					prod_q  <= '0;
					wsh_q   <= weight_q;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= {prod_q[PW-2:0], 1'b0} + addend;
					wsh_q  <= {wsh_q[WW-2:0], 1'b0};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'(WW - 1)) begin
						state_q <= ST_TONIC;
					end
				end
				ST_TONIC: begin
					tonic_q <= tonic_q + prod_rnd[LW+15:16];
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					phasic_q <= phasic_now;
					wpos_q   <= (wpos_q == AW'(scst_pkg::WINDOW_LENGTH - 1)) ? '0 : wpos_q + 1'b1;
					if (fill_q != scst_pkg::FILL_W'(scst_pkg::WINDOW_LENGTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					if (phase_q + 1'b1 >= scst_pkg::PHASE_W'(scst_pkg::RECOUNT_PERIOD)) begin
						phase_q      <= '0;
						scan_addr_q  <= '0;
						scan_issue_q <= 1'b1;
						count_q      <= '0;
						inside_q     <= 1'b0;
						state_q      <= ST_SCAN;
					end else begin
						phase_q <= phase_q + 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (scan_issue_q) begin
						if (scan_addr_q == AW'(scst_pkg::WINDOW_LENGTH - 1)) begin
							scan_issue_q <= 1'b0;
						end else begin
							scan_addr_q <= scan_addr_q + 1'b1;
						end
					end
					if (rd_act_s1) begin
						if (enter_hit && count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
						inside_q <= inside_mid && !(sample < exit_q);
						if (rd_last_s1) begin
							held_q  <= (enter_hit && count_q != '1) ? count_q + 1'b1 : count_q;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_tonic_q  <= tonic_q;
						out_phasic_q <= phasic_q;
						out_rate_q   <= held_q;
						out_score_q  <= score;
						out_band_q   <= band;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = state_q == ST_IDLE;
	assign out_valid    = out_valid_q;
	assign tonic_level  = out_tonic_q;
	assign phasic_level = out_phasic_q;
	assign event_rate   = out_rate_q;
	assign stress_pct   = out_score_q;
	assign arousal_band = out_band_q;

	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= AW'(scst_pkg::WINDOW_LENGTH - 1))
		else $error("window write position out of range");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= scst_pkg::FILL_W'(scst_pkg::WINDOW_LENGTH))
		else $error("fill count beyond window length");

	a_write_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |=> (state_q == ST_SCAN || state_q == ST_DONE))
		else $error("write step not followed by scan or result");

	a_scan_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && state_q != $past(state_q)) |=> 
		(state_q == ST_DONE || phase_q == '0))
		else $error("recount started with a nonzero phase");

endmodule
